// ===== hdl/vdi_pkg.sv =====
// Package for the vertex deduplication indexer: field widths, opcodes and
// the IEEE single-precision equality used to match stored vertices.
// No dependencies.
package vdi_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned COORD_W         = 32;
  localparam int unsigned VTX_W           = 3 * COORD_W;
  localparam int unsigned IDX_W           = 10;
  localparam int unsigned CNT_W           = 11;

  // Magnitude of infinity; any larger magnitude is a NaN.
  localparam logic [COORD_W-2:0] INF_MAG = 31'h7F80_0000;

  typedef enum logic [0:0] {
    OP_CLEAR = 1'b0,
    OP_ADD   = 1'b1
  } opcode_t;

  // True when the bit pattern encodes a NaN.
  function automatic logic coord_is_nan(input logic [COORD_W-1:0] v);
    return v[COORD_W-2:0] > INF_MAG;
  endfunction

  // Floating-point equality: NaN never matches, +0 equals -0.
  function automatic logic coord_equal(input logic [COORD_W-1:0] a,
                                       input logic [COORD_W-1:0] b);
    logic both_zero;
    both_zero = (a[COORD_W-2:0] == '0) && (b[COORD_W-2:0] == '0);
    return !coord_is_nan(a) && !coord_is_nan(b) && ((a == b) || both_zero);
  endfunction

  // A vertex is packed as {x, y, z}; all three coordinates must match.
  function automatic logic vertex_equal(input logic [VTX_W-1:0] a,
                                        input logic [VTX_W-1:0] b);
    return coord_equal(a[3*COORD_W-1:2*COORD_W], b[3*COORD_W-1:2*COORD_W]) &&
           coord_equal(a[2*COORD_W-1:COORD_W],   b[2*COORD_W-1:COORD_W])   &&
           coord_equal(a[COORD_W-1:0],           b[COORD_W-1:0]);
  endfunction

endpackage

// ===== hdl/vdi_if.sv =====
// Valid/ready channel interfaces for the vertex deduplication indexer:
// one for incoming vertex beats, one for result beats. Depends on vdi_pkg.
interface vdi_in_if;
  import vdi_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [COORD_W-1:0] x_bits;
  logic [COORD_W-1:0] y_bits;
  logic [COORD_W-1:0] z_bits;
  logic               last_in;

  modport source (output valid, opcode, x_bits, y_bits, z_bits, last_in, input ready);
  modport sink   (input valid, opcode, x_bits, y_bits, z_bits, last_in, output ready);
endinterface

interface vdi_out_if;
  import vdi_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] vertex_index;
  logic             is_new;
  logic             full_flag;
  logic [CNT_W-1:0] unique_count;
  logic             last_out;

  modport source (output valid, vertex_index, is_new, full_flag, unique_count, last_out,
                  input ready);
  modport sink   (input valid, vertex_index, is_new, full_flag, unique_count, last_out,
                  output ready);
endinterface

// ===== hdl/vdi_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read
// port. No dependencies.
module vdi_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/vertex_dedup_indexer.sv =====
// Vertex deduplication indexer, top level. Depends on vdi_pkg, the channel
// interfaces in vdi_if and the vdi_ram vertex store.
//
// Usage: each beat on in_ch either clears the vertex table (opcode clear)
// or adds one vertex given as three IEEE single bit patterns. Every input
// beat yields exactly one result beat on out_ch: the position of the first
// stored vertex that compares equal, or the position at which the vertex
// was appended, with the new flag, the full flag, the unique count and a
// copy of the last marker.
// The stored vertices sit in a RAM with a registered read; the search reads
// one entry per cycle in insertion order. An add beat passes from ST_IDLE
// through ST_SEARCH and ST_FINISH into the output register; a clear beat
// goes from ST_IDLE straight to ST_FINISH. The next beat is taken once the
// block is back in ST_IDLE. One beat is in work at a time; in_ch.ready
// is high only while the block waits for a beat. While the receiver stalls,
// the next beat may already be searched; its result waits until the output
// register is free. Reset (rst_n low, synchronous) empties the table at
// once; the RAM needs no clearing since only entries below the unique count
// are ever read.
module vertex_dedup_indexer #(
  parameter int unsigned TABLE_DEPTH = vdi_pkg::TABLE_DEPTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  vdi_in_if.sink  in_ch,
  vdi_out_if.source out_ch
);
  import vdi_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [VTX_W-1:0] vtx_r, vtx_nxt;
  logic             last_r, last_nxt;
  logic [AW-1:0]    res_idx_r, res_idx_nxt;
  logic             res_new_r, res_new_nxt;
  logic             res_full_r, res_full_nxt;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_new_r;
  logic             out_full_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_last_r;

  logic             in_fire;
  logic             out_free;
  logic             out_load;
  logic [VTX_W-1:0] rd_data;
  logic             hit;
  logic             cmp_last;
  logic             miss;
  logic             has_room;
  logic             rd_en;
  logic             wr_en;

  // Vertex store.
  vdi_ram #(
    .WIDTH (VTX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (vtx_r),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // Handshake and search status.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = (state_r == ST_FINISH) && out_free;

  assign hit      = cmp_vld_r && vertex_equal(rd_data, vtx_r);
  assign cmp_last = (CW'(cmp_idx_r) + CW'(1)) == cnt_r;
  // Either the last stored entry failed to match or the table was empty.
  assign miss     = (cmp_vld_r && !hit && cmp_last) || (!cmp_vld_r && (rd_idx_r >= cnt_r));
  assign has_room = cnt_r < DEPTH_C;

  assign rd_en = (state_r == ST_SEARCH) && !hit && !miss;
  assign wr_en = (state_r == ST_SEARCH) && miss && has_room;

  // Sequencer: accept a beat, walk the store one entry a cycle, then hand
  // the result to the output register.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    vtx_nxt      = vtx_r;
    last_nxt     = last_r;
    res_idx_nxt  = res_idx_r;
    res_new_nxt  = res_new_r;
    res_full_nxt = res_full_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          last_nxt   = in_ch.last_in;
          vtx_nxt    = {in_ch.x_bits, in_ch.y_bits, in_ch.z_bits};
          rd_idx_nxt = '0;
          if (in_ch.opcode == OP_CLEAR) begin
            cnt_nxt      = '0;
            res_idx_nxt  = '0;
            res_new_nxt  = 1'b0;
            res_full_nxt = 1'b0;
            state_nxt    = ST_FINISH;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          res_idx_nxt  = cmp_idx_r;
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          state_nxt    = ST_FINISH;
        end else if (miss) begin
          if (has_room) begin
            res_idx_nxt  = cnt_r[AW-1:0];
            res_new_nxt  = 1'b1;
            res_full_nxt = 1'b0;
            cnt_nxt      = cnt_r + CW'(1);
          end else begin
            res_idx_nxt  = '0;
            res_new_nxt  = 1'b0;
            res_full_nxt = 1'b1;
          end
          state_nxt = ST_FINISH;
        end else begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[AW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // Working payload registers.
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    vtx_r      <= vtx_nxt;
    last_r     <= last_nxt;
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
  end

  // Output register: holds a result beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= IDX_W'(res_idx_r);
      out_new_r   <= res_new_r;
      out_full_r  <= res_full_r;
      out_count_r <= CNT_W'(cnt_r);
      out_last_r  <= last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vertex_index = out_index_r;
  assign out_ch.is_new       = out_new_r;
  assign out_ch.full_flag    = out_full_r;
  assign out_ch.unique_count = out_count_r;
  assign out_ch.last_out     = out_last_r;

`ifndef SYNTHESIS
  // The unique count never exceeds the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("unique count exceeds table depth");

  // Data under comparison always comes from a valid entry.
  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (CW'(cmp_idx_r) < cnt_r))
    else $error("compared entry lies beyond the unique count");

  // Appending a vertex grows the count by exactly one.
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("append did not advance the unique count");

  // A clear beat empties the table.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.opcode == OP_CLEAR)) |=> (cnt_r == '0))
    else $error("clear beat left entries in the table");

  // A result is never both newly stored and rejected for lack of room.
  a_new_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_full_r))
    else $error("result flagged as both new and full");
`endif

endmodule

// ===== tb/vdi_index_checker.sv =====
// Index checker for the vertex deduplication indexer: watches both channels,
// keeps its own vertex table and compares every result beat in order.
// Depends on vdi_pkg and the channel interfaces in vdi_if.
module vdi_index_checker #(
  parameter int unsigned TABLE_DEPTH = vdi_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vdi_in_if           in_mon,
  vdi_out_if          out_mon,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import vdi_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             is_new;
    logic             full;
    logic [CNT_W-1:0] count;
    logic             last;
  } index_beat_t;

  // Shadow of the unique vertex table, packed as {x, y, z}.
  logic [VTX_W-1:0] known_vertices [TABLE_DEPTH];
  int unsigned      known_count;
  index_beat_t      predicted_indices [$];

  // A coordinate holds a NaN when its exponent is all ones and its fraction is not zero.
  function automatic bit coord_holds_nan(logic [COORD_W-1:0] c);
    return (c[30:23] == 8'hFF) && (c[22:0] != '0);
  endfunction

  function automatic bit coords_match(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    if (coord_holds_nan(a) || coord_holds_nan(b)) return 1'b0;
    // Zeros of either sign compare equal.
    if ((a[COORD_W-2:0] == '0) && (b[COORD_W-2:0] == '0)) return 1'b1;
    return a == b;
  endfunction

  function automatic bit vertices_match(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
    for (int c = 0; c < 3; c++) begin
      if (!coords_match(a[c*COORD_W +: COORD_W], b[c*COORD_W +: COORD_W])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one input beat to the shadow table and returns the index beat it yields.
  function automatic index_beat_t index_vertex(opcode_t op, logic [VTX_W-1:0] v, logic last);
    index_beat_t r;
    bit          found;
    int unsigned hit;
    r      = '0;
    r.last = last;
    found  = 1'b0;
    hit    = 0;
    if (op == OP_CLEAR) begin
      known_count = 0;
      return r;
    end
    for (int unsigned i = 0; i < known_count && !found; i++) begin
      if (vertices_match(known_vertices[i], v)) begin
        found = 1'b1;
        hit   = i;
      end
    end
    if (found) begin
      r.idx = hit[IDX_W-1:0];
    end else if (known_count < TABLE_DEPTH) begin
      known_vertices[known_count] = v;
      r.idx       = known_count[IDX_W-1:0];
      r.is_new    = 1'b1;
      known_count = known_count + 1;
    end else begin
      r.full = 1'b1;
    end
    r.count = known_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic note_failure(string what, index_beat_t want, index_beat_t seen);
    mismatch_count = mismatch_count + 1;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected idx %0d new %0b full %0b count %0d last %0b,",
               $realtime, what, want.idx, want.is_new, want.full, want.count, want.last);
      $display("    got idx %0d new %0b full %0b count %0d last %0b",
               seen.idx, seen.is_new, seen.full, seen.count, seen.last);
    end
  endtask

  // Predict on every input beat, compare on every result beat.
  always @(posedge clk) begin
    index_beat_t seen;
    index_beat_t want;
    index_beat_t fresh;
    if (!rst_n) begin
      known_count = 0;
      predicted_indices.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        fresh = index_vertex(opcode_t'(in_mon.opcode),
                             {in_mon.x_bits, in_mon.y_bits, in_mon.z_bits},
                             in_mon.last_in);
        predicted_indices = {predicted_indices, fresh};
      end
      if (out_mon.valid && out_mon.ready) begin
        seen.idx    = out_mon.vertex_index;
        seen.is_new = out_mon.is_new;
        seen.full   = out_mon.full_flag;
        seen.count  = out_mon.unique_count;
        seen.last   = out_mon.last_out;
        if (predicted_indices.size() == 0) begin
          note_failure("result beat with nothing outstanding", '0, seen);
        end else begin
          want = predicted_indices.pop_front();
          if (seen.idx !== want.idx || seen.is_new !== want.is_new ||
              seen.full !== want.full || seen.count !== want.count ||
              seen.last !== want.last) begin
            note_failure("result beat mismatch", want, seen);
          end
        end
      end
    end
    pending_count = predicted_indices.size();
  end

endmodule

// ===== tb/tb_vertex_dedup_indexer.sv =====
// Top of the vertex deduplication indexer testbench: clock, reset, vertex
// stimulus and the final verdict. Depends on vdi_pkg, vdi_if, the block
// itself and vdi_index_checker.
module tb_vertex_dedup_indexer;
  timeunit 1ns;
  timeprecision 1ps;
  import vdi_pkg::*;

  localparam int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int unsigned PHASE_ITEMS = 187;
  localparam int unsigned IDLE_LIMIT  = 20000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned beats_sent;
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned pending;

  vdi_in_if  in_ch ();
  vdi_out_if out_ch ();

  vertex_dedup_indexer #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vdi_index_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_index_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  always #1 clk = ~clk;

  // Result receiver: stalls at random according to the current phase.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one beat after a random gap and holds it until it is taken.
  task automatic send_beat(opcode_t op, logic [VTX_W-1:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.x_bits  <= v[3*COORD_W-1:2*COORD_W];
    in_ch.y_bits  <= v[2*COORD_W-1:COORD_W];
    in_ch.z_bits  <= v[COORD_W-1:0];
    in_ch.last_in <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Holds the sender back until every outstanding result beat has arrived.
  task automatic drain_indices();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] nan_coord();
    logic [22:0] frac;
    frac = 23'($urandom);
    if (frac == '0) frac = 23'd1;
    return {1'($urandom_range(1)), 8'hFF, frac};
  endfunction

  // Coordinates biased towards signed zeros, infinities and a few repeated values,
  // so that vertices often share single coordinates.
  function automatic logic [COORD_W-1:0] interesting_coord();
    logic s;
    s = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1: return {s, 31'h0000_0000};
      2: return {s, 31'h7F80_0000};
      3, 4: begin
        case ($urandom_range(3))
          0: return {s, 31'h3F80_0000};
          1: return {s, 31'h0000_0001};
          2: return {s, 31'h7F7F_FFFF};
          default: return {s, 31'h0080_0000};
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VTX_W-1:0] fresh_vertex();
    return {interesting_coord(), interesting_coord(), interesting_coord()};
  endfunction

  function automatic logic [VTX_W-1:0] with_nan(logic [VTX_W-1:0] v);
    int unsigned c;
    c = $urandom_range(2);
    v[c*COORD_W +: COORD_W] = nan_coord();
    return v;
  endfunction

  // Re-signs any zero coordinate; the vertex must still compare equal.
  function automatic logic [VTX_W-1:0] flip_zero_signs(logic [VTX_W-1:0] v);
    for (int c = 0; c < 3; c++) begin
      if (v[c*COORD_W +: COORD_W-1] == '0) v[c*COORD_W + COORD_W-1] = 1'($urandom_range(1));
    end
    return v;
  endfunction

  // Directed beats: signed zeros, NaNs that never match, infinities, one-bit
  // differences, denormals and clears on empty and filled tables.
  task automatic run_directed();
    send_beat(OP_CLEAR, {3{32'hFFFF_FFFF}}, 1'b1);
    send_beat(OP_ADD, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
    send_beat(OP_ADD, {32'h8000_0000, 32'h0000_0000, 32'h8000_0000}, 1'b0);
    send_beat(OP_ADD, {32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000}, 1'b0);
    send_beat(OP_ADD, {32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000}, 1'b0);
    send_beat(OP_ADD, {32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF}, 1'b0);
    send_beat(OP_ADD, {32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF}, 1'b0);
    send_beat(OP_ADD, {32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFE}, 1'b0);
    send_beat(OP_ADD, {32'h0000_0001, 32'h8000_0001, 32'h3F80_0000}, 1'b0);
    send_beat(OP_ADD, {32'h0000_0001, 32'h0000_0001, 32'h3F80_0000}, 1'b0);
    send_beat(OP_ADD, {32'h0000_0000, 32'h0000_0000, 32'h7F80_0001}, 1'b0);
    send_beat(OP_ADD, {32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000}, 1'b0);
    send_beat(OP_ADD, {32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1);
    send_beat(OP_CLEAR, {3{32'h0000_0000}}, 1'b0);
    send_beat(OP_ADD, {32'h8000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
    send_beat(OP_ADD, {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0);
    send_beat(OP_ADD, {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b1);
    send_beat(OP_ADD, {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0);
    send_beat(OP_CLEAR, {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b1);
  endtask

  // Random meshes: mostly a clear followed by vertices that often repeat
  // earlier ones, with stray clears and last markers mixed in.
  task automatic run_meshes(int unsigned item_budget);
    logic [VTX_W-1:0] seen_vertices [$];
    logic [VTX_W-1:0] v;
    int unsigned      stop_at;
    int unsigned      mesh_len;
    int unsigned      pick;
    logic             mark;
    stop_at = beats_sent + item_budget;
    while (beats_sent < stop_at) begin
      if ($urandom_range(5) == 0) drain_indices();
      if ($urandom_range(99) < 85) begin
        send_beat(OP_CLEAR, {$urandom, $urandom, $urandom}, 1'($urandom_range(1)));
        seen_vertices.delete();
      end
      mesh_len = ($urandom_range(9) == 0) ? $urandom_range(150, 60) : $urandom_range(40, 1);
      for (int unsigned k = 0; k < mesh_len && beats_sent < stop_at; k++) begin
        pick = $urandom_range(99);
        mark = (k == mesh_len - 1) || ($urandom_range(19) == 0);
        if (pick < 5) begin
          send_beat(OP_CLEAR, {$urandom, $urandom, $urandom}, mark);
          seen_vertices.delete();
        end else begin
          if (pick < 50 && seen_vertices.size() != 0) begin
            v = flip_zero_signs(seen_vertices[$urandom_range(seen_vertices.size() - 1)]);
          end else if (pick < 58) begin
            v = with_nan(fresh_vertex());
          end else begin
            v = fresh_vertex();
          end
          send_beat(OP_ADD, v, mark);
          seen_vertices = {seen_vertices, v};
        end
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.opcode  = OP_CLEAR;
    in_ch.x_bits  = '0;
    in_ch.y_bits  = '0;
    in_ch.z_bits  = '0;
    in_ch.last_in = 1'b0;
    rst_n         = 1'b0;
    beats_sent    = 0;
    send_idle_pct = 37;
    recv_idle_pct = 80;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_meshes(PHASE_ITEMS);

    drain_indices();
    send_idle_pct <= 80;
    recv_idle_pct <= 37;
    run_meshes(PHASE_ITEMS);

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    run_meshes(PHASE_ITEMS);

    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    // Leave room for any stray result beat to show up.
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
